### design/nonlinear_multichannel_audio_mixer_assert.svh
// Assertion macros for the nonlinear multichannel audio mixer.
// Expects signals named clk and rst in the scope of each use.
`ifndef NONLINEAR_MULTICHANNEL_AUDIO_MIXER_ASSERT_SVH
`define NONLINEAR_MULTICHANNEL_AUDIO_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked while out of reset.
`define NMAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mixer assertion failed");

// Checked during reset as well.
`define NMAM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mixer reset assertion failed");

`else

`define NMAM_ASSERT(lbl, prop)
`define NMAM_ASSERT_RST(lbl, prop)

`endif

`endif

### design/amix_pkg.sv
// Shared constants, types and Q1.15 helpers of the audio mixer.
// No dependencies; used by every module of the mixer.
`default_nettype none

package amix_pkg;

  localparam int CHANNELS = 8;
  localparam int SAMPLE_W = 16;
  localparam int MASK_W   = 8;
  // one multiply stage per channel, then scale, then sum
  localparam int NSTAGE   = CHANNELS + 2;
  localparam int IN_W     = ((CHANNELS * SAMPLE_W + MASK_W + 7) / 8) * 8;

  typedef logic [SAMPLE_W-1:0]               word_t;
  typedef logic [CHANNELS-1:0]               chmask_t;
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

  localparam word_t UNITY = 16'h8000;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic [NSTAGE-1:0] valid;
  } pipe_ctrl_t;

  // |s| as unsigned, full-scale negative gives 32768
  function automatic word_t magnitude(input word_t s);
    word_t m;
    m = s[SAMPLE_W-1] ? word_t'(~s + word_t'(1)) : s;
    return m;
  endfunction

  // (a * b) >> 15 on unsigned values up to 32768
  function automatic word_t mul_q15(input word_t a, input word_t b);
    logic [2*SAMPLE_W-1:0] p;
    p = {{SAMPLE_W{1'b0}}, a} * {{SAMPLE_W{1'b0}}, b};
    return p[2*SAMPLE_W-2:SAMPLE_W-1];
  endfunction

endpackage

`default_nettype wire

### design/amix_ctrl.sv
// Valid and load control of the mixer pipeline, with per-stage ready.
// Depends on amix_pkg.
`default_nettype none

module amix_ctrl import amix_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output pipe_ctrl_t ctl
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] valid_next;
  logic [NSTAGE-1:0] rdy;

  // a stage takes new data when empty or when the next one takes its own
  always_comb begin
    rdy[NSTAGE-1] = !valid[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  always_comb begin
    valid_next = valid;
    if (rdy[0]) begin
      valid_next[0] = in_valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        valid_next[k] = valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready  = rdy[0];
  assign ctl.load  = rdy;
  assign ctl.valid = valid;

endmodule

`default_nettype wire

### design/amix_lane.sv
// One mixing lane: the factor product chain of one channel and its scaling.
// Depends on amix_pkg; stage enables come from amix_ctrl.
`default_nettype none

module amix_lane import amix_pkg::*; (
  input  logic       clk,
  input  pipe_ctrl_t ctl,
  input  chmask_t    lane_bit,            // one-hot: which channel this lane serves
  input  frame_t     in_frame,
  input  chmask_t    in_mask,
  input  frame_t     frame_q [CHANNELS],
  input  chmask_t    mask_q  [CHANNELS],
  output word_t      scaled
);

  chmask_t later;
  word_t   prod [CHANNELS];
  word_t   own_sample;
  logic    own_active;
  word_t   own_mag;
  word_t   mag_scaled;

  // channels above this lane's own
  assign later = ~((lane_bit << 1) - chmask_t'(1));

  for (genvar k = 0; k < CHANNELS; k++) begin : g_stage
    frame_t  f_in;
    chmask_t m_in;
    word_t   p_in;

    if (k == 0) begin : g_first
      assign f_in = in_frame;
      assign m_in = in_mask;
      assign p_in = UNITY;
    end else begin : g_next
      assign f_in = frame_q[k-1];
      assign m_in = mask_q[k-1];
      assign p_in = prod[k-1];
    end

    always_ff @(posedge clk) begin
      if (ctl.load[k]) begin
        if (m_in[k] && later[k]) begin
          prod[k] <= mul_q15(p_in, UNITY - magnitude(f_in[k]));
        end else begin
          prod[k] <= p_in;
        end
      end
    end
  end

  always_comb begin
    own_sample = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (lane_bit[c]) begin
        own_sample = own_sample | frame_q[CHANNELS-1][c];
      end
    end
  end

  assign own_active = |(mask_q[CHANNELS-1] & lane_bit);
  assign own_mag    = magnitude(own_sample);
  assign mag_scaled = mul_q15(own_mag, prod[CHANNELS-1]);

  always_ff @(posedge clk) begin
    if (ctl.load[CHANNELS]) begin
      if (!own_active) begin
        scaled <= '0;
      end else if (own_sample[SAMPLE_W-1]) begin
        scaled <= word_t'(-mag_scaled);
      end else begin
        scaled <= mag_scaled;
      end
    end
  end

endmodule

`default_nettype wire

### design/amix_merge.sv
// Merge stage: sums the scaled lane values, wrapping to 16 bits.
// Depends on amix_pkg; load enable comes from amix_ctrl.
`default_nettype none

module amix_merge import amix_pkg::*; (
  input  logic       clk,
  input  pipe_ctrl_t ctl,
  input  word_t      lane_val [CHANNELS],
  output word_t      mixed
);

  word_t sum;

  always_comb begin
    sum = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum = sum + lane_val[c];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[NSTAGE-1]) begin
      mixed <= sum;
    end
  end

endmodule

`default_nettype wire

### design/nonlinear_multichannel_audio_mixer.sv
// Amplitude-product audio mixer: one frame of eight signed 16-bit samples
// and an activity mask in, one mixed 16-bit sample out. A frame is taken
// every cycle unless all stages are full and the output is stalled. The
// pipeline has CHANNELS + 2 = 10 register stages: in every lane one Q1.15
// multiply stage per channel and one scaling stage, then one summing stage.
// Empty stages close up, so input keeps flowing while a result waits at the
// output. Depends on amix_pkg, amix_ctrl, amix_lane, amix_merge and the
// assertion macro header.
`default_nettype none

`include "nonlinear_multichannel_audio_mixer_assert.svh"

module nonlinear_multichannel_audio_mixer import amix_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,   // sample_0 .. sample_7 (16 each), active_mask (8)
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata    // mixed_sample (16)
);

  pipe_ctrl_t ctl;
  frame_t     in_frame;
  chmask_t    in_mask;
  frame_t     frame_q [CHANNELS];
  chmask_t    mask_q  [CHANNELS];
  word_t      lane_val [CHANNELS];
  word_t      mixed;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_unpack
    assign in_frame[c] = s_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
  end
  assign in_mask = s_axis_tdata[CHANNELS*SAMPLE_W +: CHANNELS];

  amix_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .ctl       (ctl)
  );

  // frame and mask travel alongside the product chain
  for (genvar k = 0; k < CHANNELS; k++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (ctl.load[k]) begin
        if (k == 0) begin
          frame_q[k] <= in_frame;
          mask_q[k]  <= in_mask;
        end else begin
          frame_q[k] <= frame_q[(k == 0) ? 0 : k-1];
          mask_q[k]  <= mask_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    amix_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .lane_bit (chmask_t'(1) << c),
      .in_frame (in_frame),
      .in_mask  (in_mask),
      .frame_q  (frame_q),
      .mask_q   (mask_q),
      .scaled   (lane_val[c])
    );
  end

  amix_merge u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .lane_val (lane_val),
    .mixed    (mixed)
  );

  assign m_axis_tvalid = ctl.valid[NSTAGE-1];
  assign m_axis_tdata  = mixed;

  `NMAM_ASSERT_RST(a_reset_empties, rst |=> !m_axis_tvalid)
  `NMAM_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> ctl.valid[0])
  `NMAM_ASSERT(a_stall_only_full, !s_axis_tready |-> (&ctl.valid))
  `NMAM_ASSERT(a_held_result, (m_axis_tvalid && !m_axis_tready) |=> $stable(mixed))

endmodule

`default_nettype wire
